@@ rtl/mcch_pkg.sv @@
// Shared types and constants for the monotone chain convex hull block.
`timescale 1ns / 1ps
package mcch_pkg;

  // Fewest points for which a hull is built; smaller sets are echoed.
  localparam int unsigned MIN_HULL_POINTS = 3;

  // Hull engine sequencer, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_LWAIT = 9'b000000100,
    ST_PUSH  = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_CMP   = 9'b000100000,
    ST_AWAIT = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_EWAIT = 9'b100000000
  } hull_state_t;

  // Head of the job queue as seen by the hull engine.
  typedef struct packed {
    logic valid;
    logic ovf;
  } job_ctl_t;

endpackage

@@ rtl/monotone_chain_convex_hull.sv @@
// Top level of the 2D monotone chain convex hull block.
//
// Channel | Direction | Fields                                        | Handshake
// in_     | input     | x_coord, y_coord, last_point                  | in_valid / in_ready
// out_    | output    | hull_x, hull_y, last_vertex, truncated        | out_valid / out_ready
//
// Points load at one per cycle while no hull pass is pending. The transaction
// with last_point starts the pass and in_ready stays low until the pass ends.
// Each point of each chain passes through load, load-wait and push steps; each
// cross test adds a product step and a compare step, a pop that needs a stack
// refetch adds a stack-read step, and each vertex takes an emit and a wait step.
// Synchronous active-low reset clears the front counters and queue pointers, the
// sequencer and out_valid; the stores come out of reset unwritten. A stall at
// out_ready holds the engine in its emit step only; in_ready stays low meanwhile.
`timescale 1ns / 1ps
module monotone_chain_convex_hull
  import mcch_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_hull_x,
  output logic signed [COORD_BITS-1:0] out_hull_y,
  output logic                         out_last_vertex,
  output logic                         out_truncated
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW = $clog2(MAX_POINTS);

  logic                         st_we;
  logic [IW-1:0]                st_addr;
  logic signed [COORD_BITS-1:0] st_x, st_y;
  job_ctl_t                     job_ctl;
  logic [CW-1:0]                job_n;
  logic                         job_pop;
  logic                         hull_done;

  // Front: store fill and job queue.
  mcch_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .CW         (CW),
    .IW         (IW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_last_point (in_last_point),
    .st_we         (st_we),
    .st_addr       (st_addr),
    .st_x          (st_x),
    .st_y          (st_y),
    .job_ctl       (job_ctl),
    .job_n         (job_n),
    .job_pop       (job_pop),
    .hull_done     (hull_done)
  );

  // Back: lower then upper chain (small sets echoed), vertices out through one register.
  mcch_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .CW         (CW),
    .IW         (IW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .st_we           (st_we),
    .st_addr         (st_addr),
    .st_x            (st_x),
    .st_y            (st_y),
    .job_ctl         (job_ctl),
    .job_n           (job_n),
    .job_pop         (job_pop),
    .hull_done       (hull_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hull_x      (out_hull_x),
    .out_hull_y      (out_hull_y),
    .out_last_vertex (out_last_vertex),
    .out_truncated   (out_truncated)
  );

endmodule

@@ rtl/mcch_front.sv @@
// Front end: takes point transactions, fills the point store, queues hull jobs.
`timescale 1ns / 1ps
module mcch_front
  import mcch_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned IW         = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_point,
  output logic                         st_we,
  output logic [IW-1:0]                st_addr,
  output logic signed [COORD_BITS-1:0] st_x,
  output logic signed [COORD_BITS-1:0] st_y,
  output job_ctl_t                     job_ctl,
  output logic [CW-1:0]                job_n,
  input  logic                         job_pop,
  input  logic                         hull_done
);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] q_n_r   [2];
  logic          q_ovf_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    fill_r;
  logic          accept, room, push;
  logic [CW-1:0] push_n;
  logic          push_ovf;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign room     = count_r < CW'(MAX_POINTS);
  assign push     = accept && in_last_point;
  assign push_n   = room ? CW'(count_r + CW'(1)) : count_r;
  assign push_ovf = ovf_r || !room;

  assign st_we   = accept && room;
  assign st_addr = count_r[IW-1:0];
  assign st_x    = in_x_coord;
  assign st_y    = in_y_coord;

  assign job_ctl.valid = fill_r != 2'd0;
  assign job_ctl.ovf   = q_ovf_r[rp_r];
  assign job_n         = q_n_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    busy_nxt  = busy_r;
    if (accept) begin
      if (room) begin
        count_nxt = push_n;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (push) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      busy_nxt  = 1'b1;
    end else if (hull_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      fill_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (job_pop) begin
        rp_r <= !rp_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_n_r[wp_r]   <= push_n;
      q_ovf_r[wp_r] <= push_ovf;
    end
  end

endmodule

@@ rtl/mcch_back.sv @@
// Back end: hull engine with point store, chain stack and output register.
`timescale 1ns / 1ps
module mcch_back
  import mcch_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned IW         = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         st_we,
  input  logic [IW-1:0]                st_addr,
  input  logic signed [COORD_BITS-1:0] st_x,
  input  logic signed [COORD_BITS-1:0] st_y,
  input  job_ctl_t                     job_ctl,
  input  logic [CW-1:0]                job_n,
  output logic                         job_pop,
  output logic                         hull_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_hull_x,
  output logic signed [COORD_BITS-1:0] out_hull_y,
  output logic                         out_last_vertex,
  output logic                         out_truncated
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2 * CB + 2;

  hull_state_t state_r, state_nxt;

  logic [2*CB-1:0]       pmem [MAX_POINTS];
  logic [2*CB-1:0]       smem [MAX_POINTS];
  logic [2*CB-1:0]       pt_q, stk_q;
  logic [IW-1:0]         pt_ra, stk_ra;
  logic [CW-1:0]         p_idx;

  logic [CW-1:0]         n_r, i_r, k_r, j_r, len_r;
  logic                  ovf_r, upper_r, echo_r;
  logic signed [CB-1:0]  ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [PW-1:0]  prod1_r, prod2_r;
  logic signed [CB:0]    dbx, dby, dcx, dcy;
  logic signed [PW:0]    orient;
  logic                  slot_free, last_j, last_push;

  assign slot_free = !out_valid || out_ready;
  assign last_j    = CW'(j_r + CW'(1)) == len_r;
  assign last_push = CW'(i_r + CW'(1)) == n_r;
  assign p_idx     = upper_r ? CW'(n_r - CW'(1) - i_r) : i_r;
  assign pt_ra     = (state_r == ST_LOAD) ? p_idx[IW-1:0] : j_r[IW-1:0];
  assign stk_ra    = (state_r == ST_CMP) ? IW'(k_r - CW'(3)) : j_r[IW-1:0];

  assign dbx    = (CB+1)'(bx_r) - (CB+1)'(ax_r);
  assign dby    = (CB+1)'(by_r) - (CB+1)'(ay_r);
  assign dcx    = (CB+1)'(cx_r) - (CB+1)'(ax_r);
  assign dcy    = (CB+1)'(cy_r) - (CB+1)'(ay_r);
  assign orient = (PW+1)'(prod1_r) - (PW+1)'(prod2_r);

  assign job_pop   = (state_r == ST_IDLE) && job_ctl.valid;
  assign hull_done = (state_r == ST_EWAIT) && last_j && (echo_r || upper_r);

  // Point store and chain stack: one write, one registered read each.
  always_ff @(posedge clk) begin
    if (st_we) begin
      pmem[st_addr] <= {st_x, st_y};
    end
    pt_q <= pmem[pt_ra];
    if (state_r == ST_PUSH) begin
      smem[k_r[IW-1:0]] <= {cx_r, cy_r};
    end
    stk_q <= smem[stk_ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_ctl.valid) begin
                  state_nxt = (job_n < CW'(MIN_HULL_POINTS)) ? ST_EMIT : ST_LOAD;
                end
      ST_LOAD:  state_nxt = ST_LWAIT;
      ST_LWAIT: state_nxt = (k_r > CW'(1)) ? ST_MUL : ST_PUSH;
      ST_PUSH:  state_nxt = last_push ? ST_EMIT : ST_LOAD;
      ST_MUL:   state_nxt = ST_CMP;
      ST_CMP:   begin
                  if (orient[PW] || orient == '0) begin
                    state_nxt = (k_r > CW'(2)) ? ST_AWAIT : ST_PUSH;
                  end else begin
                    state_nxt = ST_PUSH;
                  end
                end
      ST_AWAIT: state_nxt = ST_MUL;
      ST_EMIT:  if (slot_free) begin
                  state_nxt = ST_EWAIT;
                end
      ST_EWAIT: begin
                  if (!last_j) begin
                    state_nxt = ST_EMIT;
                  end else if (echo_r || upper_r) begin
                    state_nxt = ST_IDLE;
                  end else begin
                    state_nxt = ST_LOAD;
                  end
                end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EWAIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r     <= job_n;
        ovf_r   <= job_ctl.ovf;
        echo_r  <= job_n < CW'(MIN_HULL_POINTS);
        len_r   <= job_n;
        upper_r <= 1'b0;
        i_r     <= '0;
        k_r     <= '0;
        j_r     <= '0;
      end
      ST_LWAIT: begin
        {cx_r, cy_r} <= pt_q;
      end
      ST_PUSH: begin
        ax_r <= bx_r;
        ay_r <= by_r;
        bx_r <= cx_r;
        by_r <= cy_r;
        k_r  <= CW'(k_r + CW'(1));
        i_r  <= CW'(i_r + CW'(1));
        if (last_push) begin
          len_r <= k_r;
          j_r   <= '0;
        end
      end
      ST_MUL: begin
        prod1_r <= PW'(dbx * dcy);
        prod2_r <= PW'(dby * dcx);
      end
      ST_CMP: begin
        if (orient[PW] || orient == '0) begin
          bx_r <= ax_r;
          by_r <= ay_r;
          k_r  <= CW'(k_r - CW'(1));
        end
      end
      ST_AWAIT: begin
        {ax_r, ay_r} <= stk_q;
      end
      ST_EWAIT: begin
        {out_hull_x, out_hull_y} <= echo_r ? pt_q : stk_q;
        out_last_vertex <= last_j && (echo_r || upper_r);
        out_truncated   <= ovf_r;
        j_r             <= CW'(j_r + CW'(1));
        if (last_j) begin
          upper_r <= 1'b1;
          i_r     <= '0;
          k_r     <= '0;
        end
      end
      default: ;
    endcase
  end

  // A comparison always uses products formed in the cycle before.
  a_cmp_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> $past(state_r) == ST_MUL)
    else $error("compare without fresh products");

  // The chain never holds more entries than the set has points.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> k_r <= n_r)
    else $error("chain stack overrun");

  // A vertex is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EWAIT |-> !out_valid)
    else $error("output register overwritten");

  // Finishing a hull leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hull_done |=> state_r == ST_IDLE)
    else $error("engine busy after hull done");

endmodule
